// ===== hw/rtl/ppu_sar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU scroll address register package
// Event codes, address field masks, fetch address bases and the shared
// state and result types of the scroll address register block.
// ----------------------------------------------------------------------------
package ppu_sar_pkg;

   // Event codes carried on the request channel.
   typedef enum logic [3:0] {
      FUNC_CTRL_WR   = 4'd0,
      FUNC_SCROLL_WR = 4'd1,
      FUNC_ADDR_WR   = 4'd2,
      FUNC_DATA_ACC  = 4'd3,
      FUNC_STATUS_RD = 4'd4,
      FUNC_INC_X     = 4'd5,
      FUNC_INC_Y     = 4'd6,
      FUNC_COPY_X    = 4'd7,
      FUNC_COPY_Y    = 4'd8
   } func_type;

   // Address layout: coarse X, coarse Y, nametable select, fine Y.
   localparam logic [15:0] CX_MASK   = 16'h001F;
   localparam logic [15:0] CY_MASK   = 16'h03E0;
   localparam logic [15:0] NT_MASK   = 16'h0C00;
   localparam logic [15:0] NT_X_BIT  = 16'h0400;
   localparam logic [15:0] NT_Y_BIT  = 16'h0800;
   localparam logic [15:0] FY_MASK   = 16'h7000;
   localparam logic [15:0] HI_MASK   = 16'hFF00;
   localparam logic [15:0] LO_MASK   = 16'h00FF;
   localparam logic [15:0] COPY_X_MASK = CX_MASK | NT_X_BIT;
   localparam logic [15:0] COPY_Y_MASK = CY_MASK | FY_MASK | NT_Y_BIT;

   // Coarse Y row at which the vertical increment wraps the nametable.
   localparam logic [4:0] CY_LAST_ROW = 5'd29;
   localparam logic [4:0] CY_MAX      = 5'd31;
   localparam logic [15:0] INC_ONE     = 16'd1;
   localparam logic [15:0] INC_ROW     = 16'd32;

   // Fetch address bases.
   localparam logic [13:0] TILE_BASE = 14'h2000;
   localparam logic [13:0] ATTR_BASE = 14'h23C0;

   // Architectural state of the block.
   typedef struct packed {
      logic [15:0] current_address;
      logic [15:0] temporary_address;
      logic [2:0]  fine_x;
      logic        write_toggle;
      logic        increment_by_32;
   } state_type;

   // One result transaction.
   typedef struct packed {
      logic [15:0] vram_address;
      logic [2:0]  fine_x_scroll;
      logic [13:0] tile_fetch_address;
      logic [13:0] attribute_fetch_address;
      logic        second_write;
   } result_type;

endpackage

// ===== hw/rtl/ppu_sar_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU scroll address register channels
// Valid/ready channel interfaces for event requests and result responses.
// ----------------------------------------------------------------------------
interface ppu_sar_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface ppu_sar_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] vram_address;
   logic [2:0]  fine_x_scroll;
   logic [13:0] tile_fetch_address;
   logic [13:0] attribute_fetch_address;
   logic        second_write;

   modport source (output valid, output vram_address, output fine_x_scroll,
                   output tile_fetch_address, output attribute_fetch_address,
                   output second_write, input ready);
   modport sink   (input valid, input vram_address, input fine_x_scroll,
                   input tile_fetch_address, input attribute_fetch_address,
                   input second_write, output ready);
endinterface

// ===== hw/rtl/ppu_scroll_address_register.sv =====
// Flow: a request transaction is held in the input register, then its response
// is loaded into the result register once that register is free.
// Throughput: one transaction per cycle while responses are drained; the
// combinational update between the input and result registers sets that figure.
// Reset: synchronous; addresses, fine X, toggle and increment mode clear to zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU scroll address register
// Keeps the current and temporary video addresses, fine X scroll, the write toggle
// and the increment mode, and reports address, fine X and toggle after each event.
// ----------------------------------------------------------------------------
module ppu_scroll_address_register (
   input logic            clock,
   input logic            reset,
   ppu_sar_req_if.sink    req_chan,
   ppu_sar_rsp_if.source  rsp_chan
);
   import ppu_sar_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [3:0]  in_func_ff;
   logic [7:0]  in_data_ff;
   state_type   state_ff;
   state_type   state_in;
   state_type   state_upd;
   result_type  result_upd;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_result_ff;
   logic        rsp_free;
   logic        advance;
   logic        req_take;

   // Handshake: the event in the input register moves on when the result
   // register is empty or being drained this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && rsp_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   ppu_sar_update u_update (
      .state      (state_ff),
      .func       (in_func_ff),
      .data_byte  (in_data_ff),
      .state_next (state_upd),
      .result     (result_upd)
   );

   // Next values of the control registers.
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      state_in     = advance ? state_upd : state_ff;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_chan.func;
         in_data_ff <= req_chan.data_byte;
      end
      if (advance) begin
         rsp_result_ff <= result_upd;
      end
   end

   assign rsp_chan.valid                   = rsp_valid_ff;
   assign rsp_chan.vram_address            = rsp_result_ff.vram_address;
   assign rsp_chan.fine_x_scroll           = rsp_result_ff.fine_x_scroll;
   assign rsp_chan.tile_fetch_address      = rsp_result_ff.tile_fetch_address;
   assign rsp_chan.attribute_fetch_address = rsp_result_ff.attribute_fetch_address;
   assign rsp_chan.second_write            = rsp_result_ff.second_write;

   // The state changes only when an event is applied.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("State changed without an applied event.");

   // A second address write makes the current address equal the temporary one.
   a_addr_copy: assert property (@(posedge clock) disable iff (reset)
      advance && in_func_ff == FUNC_ADDR_WR && state_ff.write_toggle
      |=> state_ff.current_address == state_ff.temporary_address)
      else $error("Second address write did not load the current address.");

   // A status read clears the write toggle.
   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_func_ff == FUNC_STATUS_RD |=> !state_ff.write_toggle)
      else $error("Status read left the write toggle set.");

   // A freshly loaded result reports the state it left behind.
   a_result_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_result_ff.vram_address == state_ff.current_address
      && rsp_result_ff.second_write == state_ff.write_toggle)
      else $error("Result does not match the updated state.");

endmodule

// ===== hw/rtl/ppu_sar_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU scroll address register update logic
// Applies one event to the register state and forms the result fields
// from the updated state.
// ----------------------------------------------------------------------------
module ppu_sar_update (
   input  ppu_sar_pkg::state_type  state,
   input  logic [3:0]              func,
   input  logic [7:0]              data_byte,
   output ppu_sar_pkg::state_type  state_next,
   output ppu_sar_pkg::result_type result
);
   import ppu_sar_pkg::*;

   logic [15:0] cur;
   logic [15:0] tmp;
   logic [15:0] d16;
   logic [15:0] tmp_addr_lo;
   logic [4:0]  cx_inc;
   logic [15:0] cur_inc_x;
   logic [2:0]  fy;
   logic [4:0]  cy;
   logic [4:0]  cy_next;
   logic        nt_y_flip;
   logic [15:0] cur_inc_y;
   logic [15:0] v;

   assign cur = state.current_address;
   assign tmp = state.temporary_address;
   assign d16 = {8'h00, data_byte};
   assign tmp_addr_lo = (tmp & HI_MASK) | d16;

   // Coarse X increment with horizontal nametable wrap.
   assign cx_inc = cur[4:0] + 5'd1;
   always_comb begin
      cur_inc_x = {cur[15:5], cx_inc};
      if (cur[4:0] == CY_MAX) begin
         cur_inc_x = cur_inc_x ^ NT_X_BIT;
      end
   end

   // Vertical increment: fine Y carries into coarse Y, which wraps at row 30 and past row 31.
   assign fy = cur[14:12];
   assign cy = cur[9:5];
   always_comb begin
      cy_next   = cy + 5'd1;
      nt_y_flip = 1'b0;
      if (cy == CY_LAST_ROW) begin
         cy_next   = 5'd0;
         nt_y_flip = 1'b1;
      end else if (cy == CY_MAX) begin
         cy_next = 5'd0;
      end
      if (fy != 3'd7) begin
         cur_inc_y = {cur[15], fy + 3'd1, cur[11:0]};
      end else begin
         cur_inc_y = {cur[15], 3'd0, cur[11] ^ nt_y_flip, cur[10], cy_next, cur[4:0]};
      end
   end

   // Event decode.
   always_comb begin
      state_next = state;
      case (func)
         FUNC_CTRL_WR: begin
            state_next.temporary_address = (tmp & ~NT_MASK) | {4'h0, data_byte[1:0], 10'h000};
            state_next.increment_by_32   = data_byte[2];
         end
         FUNC_SCROLL_WR: begin
            if (!state.write_toggle) begin
               state_next.temporary_address = (tmp & ~CX_MASK) | {11'h000, data_byte[7:3]};
               state_next.fine_x            = data_byte[2:0];
            end else begin
               state_next.temporary_address = (tmp & ~(CY_MASK | FY_MASK))
                  | {1'b0, data_byte[2:0], 2'b00, data_byte[7:3], 5'h00};
            end
            state_next.write_toggle = ~state.write_toggle;
         end
         FUNC_ADDR_WR: begin
            if (!state.write_toggle) begin
               state_next.temporary_address = (tmp & LO_MASK)
                  | {2'b00, data_byte[5:0], 8'h00};
            end else begin
               state_next.temporary_address = tmp_addr_lo;
               state_next.current_address   = tmp_addr_lo;
            end
            state_next.write_toggle = ~state.write_toggle;
         end
         FUNC_DATA_ACC: begin
            state_next.current_address = cur + (state.increment_by_32 ? INC_ROW : INC_ONE);
         end
         FUNC_STATUS_RD: begin
            state_next.write_toggle = 1'b0;
         end
         FUNC_INC_X: begin
            state_next.current_address = cur_inc_x;
         end
         FUNC_INC_Y: begin
            state_next.current_address = cur_inc_y;
         end
         FUNC_COPY_X: begin
            state_next.current_address = (cur & ~COPY_X_MASK) | (tmp & COPY_X_MASK);
         end
         FUNC_COPY_Y: begin
            state_next.current_address = (cur & ~COPY_Y_MASK) | (tmp & COPY_Y_MASK);
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   // Result fields are taken from the state after the event.
   assign v = state_next.current_address;
   assign result.vram_address            = v;
   assign result.fine_x_scroll           = state_next.fine_x;
   assign result.tile_fetch_address      = TILE_BASE | {2'b00, v[11:0]};
   assign result.attribute_fetch_address = ATTR_BASE | {2'b00, v[11:10], 4'h0, v[9:7], v[4:2]};
   assign result.second_write            = state_next.write_toggle;

endmodule

// ===== dv/ppu_scroll_address_register_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU scroll address register testbench
// Drives event transactions into the block and checks every response against
// a cycle-free model of the address pair, fine X and write toggle. A short
// directed table walks reset values, field extremes and wrap cases, then
// random register and render sequences follow, with random stalls on both
// channels and one long response back-pressure window.
// ----------------------------------------------------------------------------
module ppu_scroll_address_register_tb;
   import ppu_sar_pkg::*;

   // Event codes outside the defined set; the block must leave its state alone.
   localparam logic [3:0] FUNC_RSVD_FIRST = 4'd9;
   localparam logic [3:0] FUNC_RSVD_LAST  = 4'd15;

   localparam int RANDOM_EVENTS     = 850;
   localparam int LONG_STALL_AT     = 300;
   localparam int LONG_STALL_CYCLES = 100;
   localparam int DRAIN_LIMIT       = 2000;
   localparam int SETTLE_CYCLES     = 10;

   // One row of the directed table; view is only checked when pinned is set.
   typedef struct packed {
      logic [3:0] code;
      logic [7:0] din;
      logic       pinned;
      result_type view;
   } stim_row_type;

   localparam result_type RESET_VIEW = '{16'h0000, 3'd0, TILE_BASE, ATTR_BASE, 1'b0};

   localparam int DIRECTED_COUNT = 28;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{FUNC_STATUS_RD,  8'h00, 1'b1, RESET_VIEW},
      '{FUNC_CTRL_WR,    8'hFF, 1'b1, RESET_VIEW},
      '{FUNC_DATA_ACC,   8'h00, 1'b1, '{16'h0020, 3'd0, 14'h2020, 14'h23C0, 1'b0}},
      '{FUNC_SCROLL_WR,  8'hFF, 1'b1, '{16'h0020, 3'd7, 14'h2020, 14'h23C0, 1'b1}},
      '{FUNC_SCROLL_WR,  8'hFF, 1'b1, '{16'h0020, 3'd7, 14'h2020, 14'h23C0, 1'b0}},
      '{FUNC_COPY_X,     8'h00, 1'b0, '0},
      '{FUNC_COPY_Y,     8'h00, 1'b1, '{16'h7FFF, 3'd7, 14'h2FFF, 14'h2FFF, 1'b0}},
      '{FUNC_CTRL_WR,    8'h00, 1'b0, '0},
      '{FUNC_DATA_ACC,   8'h5A, 1'b1, '{16'h8000, 3'd7, 14'h2000, 14'h23C0, 1'b0}},
      '{FUNC_CTRL_WR,    8'h03, 1'b0, '0},
      '{FUNC_COPY_X,     8'hFF, 1'b0, '0},
      '{FUNC_COPY_Y,     8'hFF, 1'b1, '{16'hFFFF, 3'd7, 14'h2FFF, 14'h2FFF, 1'b0}},
      '{FUNC_DATA_ACC,   8'hFF, 1'b1, '{16'h0000, 3'd7, 14'h2000, 14'h23C0, 1'b0}},
      '{FUNC_ADDR_WR,    8'hFF, 1'b0, '0},
      '{FUNC_ADDR_WR,    8'h1F, 1'b0, '0},
      '{FUNC_INC_X,      8'h00, 1'b0, '0},
      '{FUNC_SCROLL_WR,  8'h00, 1'b0, '0},
      '{FUNC_SCROLL_WR,  8'hEF, 1'b0, '0},
      '{FUNC_COPY_Y,     8'h00, 1'b0, '0},
      '{FUNC_INC_Y,      8'h00, 1'b0, '0},
      '{FUNC_SCROLL_WR,  8'h00, 1'b0, '0},
      '{FUNC_SCROLL_WR,  8'hFF, 1'b0, '0},
      '{FUNC_COPY_Y,     8'h00, 1'b0, '0},
      '{FUNC_INC_Y,      8'h00, 1'b0, '0},
      '{FUNC_RSVD_LAST,  8'hA5, 1'b0, '0},
      '{FUNC_SCROLL_WR,  8'h55, 1'b0, '0},
      '{FUNC_STATUS_RD,  8'h00, 1'b0, '0},
      '{FUNC_ADDR_WR,    8'h80, 1'b0, '0}
   };

   logic clock;
   logic reset;

   ppu_sar_req_if req_if ();
   ppu_sar_rsp_if rsp_if ();

   ppu_scroll_address_register u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Model copy of the register state and the responses still owed by the block.
   state_type   scroll_state = '0;
   result_type  pending_results [$];
   int unsigned mismatches = 0;
   int unsigned rsp_taken = 0;
   int unsigned stim_sent = 0;
   int unsigned event_count [16];
   bit          quiet_phase = 1'b0;
   bit          pin_valid = 1'b0;
   result_type  pin_result = '0;

   // Applies one event to the model state and returns the view after it.
   function automatic result_type step_scroll_regs(input logic [3:0] code,
                                                   input logic [7:0] din);
      logic [15:0] v;
      logic [15:0] t;
      result_type  view;
      v = scroll_state.current_address;
      t = scroll_state.temporary_address;
      case (code)
         FUNC_CTRL_WR: begin
            t[11:10] = din[1:0];
            scroll_state.increment_by_32 = din[2];
         end
         FUNC_SCROLL_WR: begin
            if (!scroll_state.write_toggle) begin
               t[4:0] = din[7:3];
               scroll_state.fine_x = din[2:0];
            end else begin
               t[9:5]   = din[7:3];
               t[14:12] = din[2:0];
            end
            scroll_state.write_toggle = ~scroll_state.write_toggle;
         end
         FUNC_ADDR_WR: begin
            if (!scroll_state.write_toggle) begin
               t[15:8] = {2'b00, din[5:0]};
            end else begin
               t[7:0] = din;
               v = t;
            end
            scroll_state.write_toggle = ~scroll_state.write_toggle;
         end
         FUNC_DATA_ACC: begin
            v = v + (scroll_state.increment_by_32 ? INC_ROW : INC_ONE);
         end
         FUNC_STATUS_RD: begin
            scroll_state.write_toggle = 1'b0;
         end
         FUNC_INC_X: begin
            // Stepping off the last column moves to the horizontal neighbor table.
            if (v[4:0] == 5'd31) begin
               v[4:0] = 5'd0;
               v[10]  = ~v[10];
            end else begin
               v[4:0] = v[4:0] + 5'd1;
            end
         end
         FUNC_INC_Y: begin
            // Fine Y carries into coarse Y; row 29 flips the vertical table,
            // row 31 (attribute area) wraps without flipping.
            if (v[14:12] != 3'd7) begin
               v[14:12] = v[14:12] + 3'd1;
            end else begin
               v[14:12] = 3'd0;
               if (v[9:5] == CY_LAST_ROW) begin
                  v[9:5] = 5'd0;
                  v[11]  = ~v[11];
               end else if (v[9:5] == CY_MAX) begin
                  v[9:5] = 5'd0;
               end else begin
                  v[9:5] = v[9:5] + 5'd1;
               end
            end
         end
         FUNC_COPY_X: begin
            v = (v & ~COPY_X_MASK) | (t & COPY_X_MASK);
         end
         FUNC_COPY_Y: begin
            v = (v & ~COPY_Y_MASK) | (t & COPY_Y_MASK);
         end
         default: begin
         end
      endcase
      scroll_state.current_address   = v;
      scroll_state.temporary_address = t;
      view.vram_address            = v;
      view.fine_x_scroll           = scroll_state.fine_x;
      view.tile_fetch_address      = TILE_BASE | {2'b00, v[11:0]};
      view.attribute_fetch_address = ATTR_BASE | {2'b00, v[11:10], 4'b0000, v[9:7], v[4:2]};
      view.second_write            = scroll_state.write_toggle;
      return view;
   endfunction

   // Offers one event after a random gap, none in a quiet phase, and returns once it is accepted.
   task automatic send_event(input logic [3:0] code, input logic [7:0] din,
                             input logic pinned, input result_type view);
      int unsigned gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= code;
      req_if.data_byte <= din;
      pin_valid  = pinned;
      pin_result = view;
      stim_sent++;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_random(input logic [3:0] code);
      send_event(code, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit well beyond the slowest legal run.
   initial begin
      #4ms;
      $display("[ppu_scroll_address_register] ERROR");
      $finish;
   end

   // Scoreboard: predict on each accepted event, compare each accepted response.
   always @(posedge clock) begin : scoreboard
      result_type predicted;
      result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predicted = step_scroll_regs(req_if.func, req_if.data_byte);
            pending_results.push_back(pin_valid ? pin_result : predicted);
            event_count[req_if.func]++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken++;
            got = '{rsp_if.vram_address, rsp_if.fine_x_scroll, rsp_if.tile_fetch_address,
                    rsp_if.attribute_fetch_address, rsp_if.second_write};
            if (pending_results.size() == 0) begin
               $error("response transaction with no event outstanding");
               mismatches++;
            end else begin
               predicted = pending_results.pop_front();
               if (got.vram_address !== predicted.vram_address) begin
                  $error("vram_address: expected %h, got %h",
                         predicted.vram_address, got.vram_address);
                  mismatches++;
               end
               if (got.fine_x_scroll !== predicted.fine_x_scroll) begin
                  $error("fine_x_scroll: expected %0d, got %0d",
                         predicted.fine_x_scroll, got.fine_x_scroll);
                  mismatches++;
               end
               if (got.tile_fetch_address !== predicted.tile_fetch_address) begin
                  $error("tile_fetch_address: expected %h, got %h",
                         predicted.tile_fetch_address, got.tile_fetch_address);
                  mismatches++;
               end
               if (got.attribute_fetch_address !== predicted.attribute_fetch_address) begin
                  $error("attribute_fetch_address: expected %h, got %h",
                         predicted.attribute_fetch_address, got.attribute_fetch_address);
                  mismatches++;
               end
               if (got.second_write !== predicted.second_write) begin
                  $error("second_write: expected %0d, got %0d",
                         predicted.second_write, got.second_write);
                  mismatches++;
               end
            end
         end
      end
   end

   // Response side: random stalls per transaction, plus one long hold-off
   // that backs the block up into its request channel.
   initial begin : rsp_sink
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 9);
         if (rsp_taken == LONG_STALL_AT) begin
            stall = LONG_STALL_CYCLES;
         end
         repeat (stall) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   // Stimulus: reset, directed table, random sequences, drain and verdict.
   initial begin : stimulus
      int unsigned drain;
      int unsigned renders;
      int unsigned unused;
      logic [3:0]  noise_code;
      foreach (event_count[i]) event_count[i] = 0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_CTRL_WR;
      req_if.data_byte = 8'h00;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_event(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].din,
                    DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].view);
      end

      // Random part: mostly well-formed register and render sequences.
      while (stim_sent < DIRECTED_COUNT + RANDOM_EVENTS) begin
         quiet_phase = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               send_random(FUNC_STATUS_RD);
               send_random(FUNC_SCROLL_WR);
               send_random(FUNC_SCROLL_WR);
            end
            2: begin
               send_random(FUNC_STATUS_RD);
               send_random(FUNC_ADDR_WR);
               send_random(FUNC_ADDR_WR);
               repeat ($urandom_range(0, 4)) send_random(FUNC_DATA_ACC);
            end
            3: begin
               send_random(FUNC_CTRL_WR);
            end
            4, 5, 6: begin
               repeat ($urandom_range(1, 8)) begin
                  send_random(FUNC_INC_X);
                  if ($urandom_range(0, 1) == 0) send_random(FUNC_INC_Y);
               end
               send_random(FUNC_COPY_X);
               if ($urandom_range(0, 2) == 0) send_random(FUNC_COPY_Y);
            end
            7: begin
               repeat ($urandom_range(1, 6)) send_random(FUNC_DATA_ACC);
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  noise_code = 4'($urandom_range(0, 15));
                  send_random(noise_code);
               end
            end
         endcase
      end
      quiet_phase = 1'b0;
      req_if.valid <= 1'b0;

      // Let every owed response arrive, then a few idle cycles.
      drain = 0;
      while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected responses never arrived", pending_results.size());
         mismatches++;
      end

      renders = event_count[FUNC_INC_X] + event_count[FUNC_INC_Y]
              + event_count[FUNC_COPY_X] + event_count[FUNC_COPY_Y];
      unused = 0;
      for (int c = FUNC_RSVD_FIRST; c <= FUNC_RSVD_LAST; c++) unused += event_count[c];
      $display("Events: %0d control, %0d scroll, %0d address, %0d data, %0d status,",
               event_count[FUNC_CTRL_WR], event_count[FUNC_SCROLL_WR],
               event_count[FUNC_ADDR_WR], event_count[FUNC_DATA_ACC],
               event_count[FUNC_STATUS_RD]);
      $display("  %0d render, %0d undefined codes; %0d responses checked, %0d mismatches.",
               renders, unused, rsp_taken, mismatches);
      if (mismatches == 0) begin
         $display("[ppu_scroll_address_register] OK");
      end else begin
         $display("[ppu_scroll_address_register] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ppu_sar_pkg.sv
hw/rtl/ppu_sar_if.sv
hw/rtl/ppu_sar_update.sv
hw/rtl/ppu_scroll_address_register.sv
dv/ppu_scroll_address_register_tb.sv
